// ===== sv/fsrm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the frame slot ring manager.
// No dependencies; imported by every module of the block.
package fsrm_pkg;

   localparam int SLOT_COUNT  = 4;
   localparam int SLOT_W      = $clog2(SLOT_COUNT);
   localparam int CNT_W       = $clog2(SLOT_COUNT + 1);
   localparam int BACKLOG_MAX = 7;
   localparam int BACKLOG_FULL = (SLOT_COUNT > BACKLOG_MAX) ? BACKLOG_MAX : SLOT_COUNT;

   typedef enum logic [2:0] {
      ACT_ACQ_FREE  = 3'd0,
      ACT_MARK      = 3'd1,
      ACT_POLL      = 3'd2,
      ACT_ACQ_READY = 3'd3,
      ACT_RELEASE   = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      SLOT_FREE      = 2'd0,
      SLOT_SUBMITTED = 2'd1,
      SLOT_READY     = 2'd2,
      SLOT_IN_USE    = 2'd3
   } slot_state_type;

   typedef enum logic [3:0] {
      CS_IDLE   = 4'b0001,
      CS_PREP   = 4'b0010,
      CS_SCAN   = 4'b0100,
      CS_COMMIT = 4'b1000
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic prep;
      logic scan;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_needed;
      logic scan_last;
   } dp_status_type;

endpackage

// ===== sv/fsrm_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the frame slot ring manager: request intake, scan, commit, response valid.
// Depends on fsrm_pkg; drives the datapath through ctrl_cmd_type.
module fsrm_ctrl
   import fsrm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output ctrl_cmd_type  cmd,
   input  dp_status_type status
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           commit_ok;

   assign commit_ok = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != CS_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = CS_PREP;
            end
         end
         CS_PREP: begin
            cmd.prep = 1'b1;
            state_in = status.scan_needed ? CS_SCAN : CS_COMMIT;
         end
         CS_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = CS_COMMIT;
            end
         end
         CS_COMMIT: begin
            // hold until the output register is free or being drained
            if (commit_ok) begin
               cmd.commit = 1'b1;
               state_in   = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.commit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/fsrm_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the frame slot ring manager: slot table, frame store, counters, result register.
// Depends on fsrm_pkg; steered by fsrm_ctrl.
module fsrm_dp
   import fsrm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  logic [2:0]    req_action,
   input  logic [1:0]    req_slot_index,
   input  logic [31:0]   req_frame_seq,
   input  logic [3:0]    req_fence_done_mask,
   input  logic          req_retire_busy,
   output logic          rsp_found,
   output logic [1:0]    rsp_granted_slot,
   output logic [2:0]    rsp_backlog,
   output logic [31:0]   rsp_dropped_count,
   output logic [31:0]   rsp_consumed_count
);

   localparam logic [SLOT_W:0]   SlotLimit = (SLOT_W + 1)'(SLOT_COUNT);
   localparam logic [SLOT_W-1:0] LastSlot  = SLOT_W'(SLOT_COUNT - 1);

   // slot table and counters
   slot_state_type    status_ff [SLOT_COUNT];
   slot_state_type    status_in [SLOT_COUNT];
   logic [31:0]       frame_ff  [SLOT_COUNT];
   logic [SLOT_W-1:0] sub_ptr_ff, sub_ptr_in;
   logic [2:0]        backlog_ff, backlog_in;
   logic [31:0]       drop_ff, drop_in;
   logic [31:0]       cons_ff, cons_in;

   // captured request beat
   logic [2:0]        act_ff;
   logic [1:0]        idx_ff;
   logic [31:0]       frame_req_ff;
   logic [3:0]        mask_ff;
   logic              busy_ff;

   // scan state
   logic [SLOT_W-1:0] cnt_ff, cnt_in;
   logic              have_ff, have_in;
   logic [SLOT_W-1:0] best_ff, best_in;
   logic [31:0]       best_frame_ff, best_frame_in;

   // result register
   logic              found_ff, found_in;
   logic [1:0]        grant_ff, grant_in;
   logic [2:0]        out_backlog_ff;
   logic [31:0]       out_drop_ff, out_cons_ff;

   logic [SLOT_COUNT-1:0] fence_vec;
   logic [SLOT_W:0]       wrap_sum;
   logic [SLOT_W-1:0]     free_slot;
   logic [SLOT_W-1:0]     idx_slot;
   logic [SLOT_W-1:0]     rd_addr;
   slot_state_type        rd_status;
   logic [31:0]           rd_frame;
   logic                  idx_ok;
   logic                  frame_we;
   logic [CNT_W-1:0]      waiting;

   function automatic slot_state_type req_busy_state(input logic busy);
      return busy ? SLOT_IN_USE : SLOT_FREE;
   endfunction

   // fence bits beyond the mask read as never signalled
   assign fence_vec = SLOT_COUNT'(mask_ff);
   assign idx_ok    = int'(idx_ff) < SLOT_COUNT;
   assign idx_slot  = SLOT_W'(idx_ff);

   always_comb begin
      wrap_sum = {1'b0, sub_ptr_ff} + {1'b0, cnt_ff};
      if (wrap_sum >= SlotLimit) begin
         wrap_sum = wrap_sum - SlotLimit;
      end
      free_slot = wrap_sum[SLOT_W-1:0];
   end

   always_comb begin
      if (cmd.commit) begin
         rd_addr = idx_slot;
      end else if (act_ff == ACT_ACQ_FREE) begin
         rd_addr = free_slot;
      end else begin
         rd_addr = cnt_ff;
      end
   end

   assign rd_status = status_ff[rd_addr];
   assign rd_frame  = frame_ff[cnt_ff];

   assign status.scan_needed = (act_ff == ACT_ACQ_FREE) || (act_ff == ACT_ACQ_READY);
   assign status.scan_last   = (cnt_ff == LastSlot);

   // scan step: one slot per cycle
   always_comb begin
      cnt_in        = cnt_ff;
      have_in       = have_ff;
      best_in       = best_ff;
      best_frame_in = best_frame_ff;
      if (cmd.capture) begin
         cnt_in  = '0;
         have_in = 1'b0;
      end else if (cmd.scan) begin
         cnt_in = cnt_ff + 1'b1;
         if (act_ff == ACT_ACQ_FREE) begin
            if (!have_ff && rd_status == SLOT_FREE) begin
               have_in = 1'b1;
               best_in = rd_addr;
            end
         end else if (rd_status == SLOT_READY && (!have_ff || rd_frame < best_frame_ff)) begin
            have_in       = 1'b1;
            best_in       = rd_addr;
            best_frame_in = rd_frame;
         end
      end
   end

   // slot table updates: promotion in the prep cycle, the claim or edit at commit
   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         status_in[i] = status_ff[i];
      end
      sub_ptr_in = sub_ptr_ff;
      backlog_in = backlog_ff;
      drop_in    = drop_ff;
      cons_in    = cons_ff;
      found_in   = 1'b0;
      grant_in   = '0;
      frame_we   = 1'b0;
      waiting    = '0;

      if (cmd.prep && act_ff == ACT_ACQ_READY) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (status_ff[i] == SLOT_SUBMITTED) begin
               if (fence_vec[i]) begin
                  status_in[i] = SLOT_READY;
               end else begin
                  waiting = waiting + 1'b1;
               end
            end
         end
         backlog_in = (int'(waiting) > BACKLOG_MAX) ? 3'(BACKLOG_MAX) : 3'(waiting);
      end

      if (cmd.commit) begin
         unique case (act_ff)
            ACT_ACQ_FREE: begin
               if (have_ff) begin
                  status_in[best_ff] = SLOT_IN_USE;
                  sub_ptr_in = (best_ff == LastSlot) ? '0 : best_ff + 1'b1;
                  found_in   = 1'b1;
                  grant_in   = 2'(best_ff);
               end else begin
                  drop_in    = (drop_ff == '1) ? drop_ff : drop_ff + 1'b1;
                  backlog_in = 3'(BACKLOG_FULL);
               end
            end
            ACT_MARK: begin
               if (idx_ok) begin
                  status_in[idx_slot] = SLOT_SUBMITTED;
                  frame_we = 1'b1;
               end
            end
            ACT_POLL: begin
               if (idx_ok) begin
                  if (rd_status == SLOT_SUBMITTED && fence_vec[idx_slot]) begin
                     status_in[idx_slot] = SLOT_READY;
                     found_in = 1'b1;
                  end else begin
                     found_in = (rd_status == SLOT_READY);
                  end
               end
            end
            ACT_ACQ_READY: begin
               if (have_ff) begin
                  status_in[best_ff] = SLOT_IN_USE;
                  cons_in  = (cons_ff == '1) ? cons_ff : cons_ff + 1'b1;
                  found_in = 1'b1;
                  grant_in = 2'(best_ff);
               end
            end
            ACT_RELEASE: begin
               if (idx_ok) begin
                  status_in[idx_slot] = req_busy_state(busy_ff);
               end
            end
            default: begin
               // unknown action: no change, found stays low
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            status_ff[i] <= SLOT_FREE;
         end
         sub_ptr_ff <= '0;
         backlog_ff <= '0;
         drop_ff    <= '0;
         cons_ff    <= '0;
      end else begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            status_ff[i] <= status_in[i];
         end
         sub_ptr_ff <= sub_ptr_in;
         backlog_ff <= backlog_in;
         drop_ff    <= drop_in;
         cons_ff    <= cons_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff       <= req_action;
         idx_ff       <= req_slot_index;
         frame_req_ff <= req_frame_seq;
         mask_ff      <= req_fence_done_mask;
         busy_ff      <= req_retire_busy;
      end
      if (frame_we) begin
         frame_ff[idx_slot] <= frame_req_ff;
      end
      cnt_ff        <= cnt_in;
      have_ff       <= have_in;
      best_ff       <= best_in;
      best_frame_ff <= best_frame_in;
      if (cmd.commit) begin
         found_ff       <= found_in;
         grant_ff       <= grant_in;
         out_backlog_ff <= backlog_in;
         out_drop_ff    <= drop_in;
         out_cons_ff    <= cons_in;
      end
   end

   assign rsp_found          = found_ff;
   assign rsp_granted_slot   = grant_ff;
   assign rsp_backlog        = out_backlog_ff;
   assign rsp_dropped_count  = out_drop_ff;
   assign rsp_consumed_count = out_cons_ff;

endmodule

// ===== sv/frame_slot_ring_manager.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  action, slot_index, frame_seq,
//                                          fence_done_mask, retire_busy
// rsp      out        rsp_valid/rsp_stall  found, granted_slot, backlog,
//                                          dropped_count, consumed_count
//
// Top level of the frame slot ring manager; depends on fsrm_pkg, fsrm_ctrl, fsrm_dp.
// One request at a time. Both acquires scan the slot table one slot per cycle between
// the prep and commit states; mark, poll, release and unknown actions go from prep
// straight to commit.
// Synchronous active-high reset frees all slots and clears pointer, backlog and counters.
// A stalled response is held in the output register; a new request is still taken,
// and its commit waits only until that register drains.
module frame_slot_ring_manager
   import fsrm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [1:0]  req_slot_index,
   input  logic [31:0] req_frame_seq,
   input  logic [3:0]  req_fence_done_mask,
   input  logic        req_retire_busy,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [1:0]  rsp_granted_slot,
   output logic [2:0]  rsp_backlog,
   output logic [31:0] rsp_dropped_count,
   output logic [31:0] rsp_consumed_count
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   fsrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   fsrm_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_action          (req_action),
      .req_slot_index      (req_slot_index),
      .req_frame_seq       (req_frame_seq),
      .req_fence_done_mask (req_fence_done_mask),
      .req_retire_busy     (req_retire_busy),
      .rsp_found           (rsp_found),
      .rsp_granted_slot    (rsp_granted_slot),
      .rsp_backlog         (rsp_backlog),
      .rsp_dropped_count   (rsp_dropped_count),
      .rsp_consumed_count  (rsp_consumed_count)
   );

   // a failed or non-acquire beat never names a slot
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_granted_slot == 2'd0)
      else $error("granted_slot set without a grant");

   // req_stall is raised in the cycle after a request is accepted
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken on consecutive cycles");

   a_drop_monotonic: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid) |-> rsp_dropped_count >= $past(rsp_dropped_count))
      else $error("drop counter went backwards");

   a_consume_monotonic: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid) |-> rsp_consumed_count >= $past(rsp_consumed_count))
      else $error("consume counter went backwards");

endmodule

// ===== tb/sv/frame_slot_ring_manager_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for frame_slot_ring_manager: directed and random slot requests,
// a request-level model of the slot ring, and field-wise checks of every response beat.
// Depends on fsrm_pkg and the frame_slot_ring_manager RTL.
module frame_slot_ring_manager_test;
   import fsrm_pkg::*;

   localparam int          CYCLE_LIMIT   = 300000;
   localparam int          DRAIN_CYCLES  = 40;
   localparam int          RANDOM_ITEMS  = 750;
   localparam int          IDLE_PERCENT  = 37;
   localparam int          CALM_FIRST    = 300;
   localparam int          CALM_LAST     = 450;
   localparam int          PRINT_LIMIT   = 100;
   localparam logic [2:0]  ACT_UNUSED_LO = 3'd5;
   localparam logic [2:0]  ACT_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [2:0]  action;
      logic [1:0]  slot;
      logic [31:0] frame;
      logic [3:0]  mask;
      logic        busy;
   } ring_request_type;

   typedef struct packed {
      logic        found;
      logic [1:0]  granted;
      logic [2:0]  backlog;
      logic [31:0] drops;
      logic [31:0] consumed;
   } ring_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_action = ACT_ACQ_FREE;
   logic [1:0]  req_slot_index = '0;
   logic [31:0] req_frame_seq = '0;
   logic [3:0]  req_fence_done_mask = '0;
   logic        req_retire_busy = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_found;
   logic [1:0]  rsp_granted_slot;
   logic [2:0]  rsp_backlog;
   logic [31:0] rsp_dropped_count;
   logic [31:0] rsp_consumed_count;

   ring_request_type  pending_requests[$];
   ring_answer_type   expected_answers[$];
   ring_request_type  request_on_bus;
   int                requests_taken = 0;
   int                answers_seen = 0;
   int                error_count = 0;
   int                cycle_count = 0;

   // ring model
   slot_state_type model_status [SLOT_COUNT];
   logic [31:0]    model_frame [SLOT_COUNT];
   logic           model_pending [SLOT_COUNT];
   int             model_ptr;
   logic [2:0]     model_backlog;
   logic [31:0]    model_drops;
   logic [31:0]    model_consumed;

   frame_slot_ring_manager uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_slot_index      (req_slot_index),
      .req_frame_seq       (req_frame_seq),
      .req_fence_done_mask (req_fence_done_mask),
      .req_retire_busy     (req_retire_busy),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_found           (rsp_found),
      .rsp_granted_slot    (rsp_granted_slot),
      .rsp_backlog         (rsp_backlog),
      .rsp_dropped_count   (rsp_dropped_count),
      .rsp_consumed_count  (rsp_consumed_count)
   );

   always #5 clock = ~clock;

   function automatic logic fence_hit(input logic [3:0] mask, input int i);
      return (i < 4) && mask[i];
   endfunction

   function automatic logic [31:0] bump_saturated(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic logic [2:0] clip_backlog(input int v);
      return (v > BACKLOG_MAX) ? 3'(BACKLOG_MAX) : 3'(v);
   endfunction

   task automatic clear_ring_model();
      for (int i = 0; i < SLOT_COUNT; i++) begin
         model_status[i]  = SLOT_FREE;
         model_frame[i]   = '0;
         model_pending[i] = 1'b0;
      end
      model_ptr      = 0;
      model_backlog  = '0;
      model_drops    = '0;
      model_consumed = '0;
   endtask

   task automatic predict_ring_answer(input ring_request_type it);
      ring_answer_type ans;
      int              s;
      int              waiting;
      int              best;
      bit              have;
      bit              slot_ok;
      ans     = '0;
      waiting = 0;
      best    = 0;
      have    = 1'b0;
      slot_ok = int'(it.slot) < SLOT_COUNT;
      case (it.action)
         ACT_ACQ_FREE: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               s = (model_ptr + i) % SLOT_COUNT;
               if (!have && model_status[s] == SLOT_FREE) begin
                  model_status[s] = SLOT_IN_USE;
                  model_ptr       = (s + 1) % SLOT_COUNT;
                  have            = 1'b1;
                  ans.found       = 1'b1;
                  ans.granted     = s[1:0];
               end
            end
            if (!have) begin
               model_drops   = bump_saturated(model_drops);
               model_backlog = clip_backlog(SLOT_COUNT);
            end
         end
         ACT_MARK: begin
            if (slot_ok) begin
               model_frame[it.slot]   = it.frame;
               model_pending[it.slot] = 1'b0;
               model_status[it.slot]  = SLOT_SUBMITTED;
            end
         end
         ACT_POLL: begin
            if (slot_ok) begin
               if (model_status[it.slot] == SLOT_SUBMITTED && fence_hit(it.mask, it.slot))
                  model_status[it.slot] = SLOT_READY;
               ans.found = (model_status[it.slot] == SLOT_READY);
            end
         end
         ACT_ACQ_READY: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (model_status[i] == SLOT_SUBMITTED) begin
                  if (fence_hit(it.mask, i)) model_status[i] = SLOT_READY;
                  else waiting++;
               end
            end
            model_backlog = clip_backlog(waiting);
            // strict compare keeps the lowest index on equal frame numbers
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (model_status[i] == SLOT_READY &&
                   (!have || model_frame[i] < model_frame[best])) begin
                  have = 1'b1;
                  best = i;
               end
            end
            if (have) begin
               model_status[best] = SLOT_IN_USE;
               model_consumed     = bump_saturated(model_consumed);
               ans.found          = 1'b1;
               ans.granted        = best[1:0];
            end
         end
         ACT_RELEASE: begin
            if (slot_ok) begin
               if (it.busy) begin
                  model_pending[it.slot] = 1'b1;
                  model_status[it.slot]  = SLOT_IN_USE;
               end else begin
                  model_status[it.slot] = SLOT_FREE;
               end
            end
         end
         default: ;
      endcase
      ans.backlog  = model_backlog;
      ans.drops    = model_drops;
      ans.consumed = model_consumed;
      expected_answers.push_back(ans);
   endtask

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT)
         $display("[%0t] mismatch at beat %0d: %s", $realtime, answers_seen, msg);
      error_count++;
   endtask

   task automatic check_answer_beat();
      ring_answer_type want;
      if (expected_answers.size() == 0) begin
         report_mismatch("response beat with nothing expected");
      end else begin
         want = expected_answers.pop_front();
         if (rsp_found !== want.found)
            report_mismatch($sformatf("found %0b, want %0b", rsp_found, want.found));
         if (rsp_granted_slot !== want.granted)
            report_mismatch($sformatf("granted_slot %0d, want %0d",
                                      rsp_granted_slot, want.granted));
         if (rsp_backlog !== want.backlog)
            report_mismatch($sformatf("backlog %0d, want %0d", rsp_backlog, want.backlog));
         if (rsp_dropped_count !== want.drops)
            report_mismatch($sformatf("dropped_count %0h, want %0h",
                                      rsp_dropped_count, want.drops));
         if (rsp_consumed_count !== want.consumed)
            report_mismatch($sformatf("consumed_count %0h, want %0h",
                                      rsp_consumed_count, want.consumed));
      end
      answers_seen++;
   endtask

   task automatic queue_request(input logic [2:0] action, input logic [1:0] slot,
                                input logic [31:0] frame, input logic [3:0] mask,
                                input logic busy);
      ring_request_type it;
      it.action = action;
      it.slot   = slot;
      it.frame  = frame;
      it.mask   = mask;
      it.busy   = busy;
      pending_requests.push_back(it);
   endtask

   function automatic logic [31:0] pick_frame();
      case ($urandom_range(0, 3))
         0, 1:    return 32'($urandom_range(0, 7));  // small values force ties
         2:       return $urandom();
         default: return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
      endcase
   endfunction

   function automatic logic [2:0] pick_action();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 20) return ACT_ACQ_FREE;
      if (roll < 45) return ACT_MARK;
      if (roll < 60) return ACT_POLL;
      if (roll < 80) return ACT_ACQ_READY;
      if (roll < 95) return ACT_RELEASE;
      return 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
   endfunction

   function automatic bit calm_window(input int n);
      return (n >= CALM_FIRST) && (n < CALM_LAST);
   endfunction

   // request driver: predict on each accepted beat, then offer the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_ring_answer(request_on_bus);
            requests_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() != 0 &&
                (calm_window(requests_taken) || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               request_on_bus = pending_requests.pop_front();
               req_action          <= request_on_bus.action;
               req_slot_index      <= request_on_bus.slot;
               req_frame_seq       <= request_on_bus.frame;
               req_fence_done_mask <= request_on_bus.mask;
               req_retire_busy     <= request_on_bus.busy;
               req_valid           <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_answer_beat();
         rsp_stall <= !calm_window(answers_seen) && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      clear_ring_model();

      // directed: empty ring, fill, drop, then ordering and release cases
      queue_request(ACT_ACQ_READY, 2'd0, 32'd0, 4'hF, 1'b0);
      queue_request(ACT_ACQ_FREE, 2'd3, 32'd0, 4'h0, 1'b0);
      queue_request(ACT_ACQ_FREE, 2'd0, 32'd0, 4'h0, 1'b1);
      queue_request(ACT_ACQ_FREE, 2'd0, 32'd0, 4'h0, 1'b0);
      queue_request(ACT_ACQ_FREE, 2'd0, 32'd0, 4'h0, 1'b0);
      queue_request(ACT_ACQ_FREE, 2'd0, 32'd0, 4'hF, 1'b0);
      queue_request(ACT_MARK, 2'd0, 32'hFFFF_FFFF, 4'h0, 1'b0);
      queue_request(ACT_MARK, 2'd1, 32'd0, 4'hF, 1'b0);
      queue_request(ACT_MARK, 2'd2, 32'd5, 4'h0, 1'b0);
      queue_request(ACT_MARK, 2'd3, 32'd5, 4'h0, 1'b1);
      queue_request(ACT_POLL, 2'd0, 32'd0, 4'h0, 1'b0);
      queue_request(ACT_POLL, 2'd0, 32'd0, 4'h1, 1'b0);
      queue_request(ACT_POLL, 2'd0, 32'd0, 4'h0, 1'b0);
      queue_request(ACT_ACQ_READY, 2'd0, 32'd0, 4'b0110, 1'b0);
      queue_request(ACT_ACQ_READY, 2'd0, 32'd0, 4'b1000, 1'b0);
      queue_request(ACT_RELEASE, 2'd2, 32'd0, 4'h0, 1'b1);
      queue_request(ACT_MARK, 2'd2, 32'd5, 4'h0, 1'b0);
      queue_request(ACT_RELEASE, 2'd1, 32'd0, 4'h0, 1'b0);
      queue_request(ACT_ACQ_FREE, 2'd0, 32'd0, 4'h0, 1'b0);
      queue_request(ACT_ACQ_READY, 2'd0, 32'd0, 4'h0, 1'b0);
      queue_request(ACT_UNUSED_LO, 2'd3, $urandom(), 4'hF, 1'b1);
      queue_request(ACT_UNUSED_LO + 3'd1, 2'd1, $urandom(), 4'h5, 1'b0);
      queue_request(ACT_UNUSED_HI, 2'd2, $urandom(), 4'hA, 1'b1);
      queue_request(ACT_RELEASE, 2'd0, 32'd0, 4'h0, 1'b0);
      queue_request(ACT_POLL, 2'd3, 32'd0, 4'hF, 1'b0);

      for (int n = 0; n < RANDOM_ITEMS; n++)
         queue_request(pick_action(), 2'($urandom_range(0, 3)), pick_frame(),
                       4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/fsrm_pkg.sv
sv/fsrm_ctrl.sv
sv/fsrm_dp.sv
sv/frame_slot_ring_manager.sv
tb/sv/frame_slot_ring_manager_test.sv
